>>> src/lpsp_pkg.sv
// Shared constants, codes and types for the looping PCM sample player.
`default_nettype none
package lpsp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CLIP_FRAMES = 65536;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int ADDR_W      = $clog2(CLIP_FRAMES);
    localparam int LEN_W       = $clog2(CLIP_FRAMES + 1);
    localparam int FRAME_W     = 2 * SAMPLE_BITS;

    // Product of a (SAMPLE_BITS+1)-bit signed operand and the gain made signed.
    localparam int PROD_W      = SAMPLE_BITS + 1 + GAIN_W + 1;

    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    localparam int IN_FIELDS_W  = 4 * SAMPLE_BITS + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SAMPLE_BITS + 1 + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_RENDER = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_LOAD_FULL  = 2'd1,
        ST_PLAY_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 1'd0,
        CFG_MODE = 1'd1
    } t_cfg_idx;

endpackage
`default_nettype wire

>>> src/looping_pcm_sample_player_top.sv
// Looping PCM sample player: command decode, clip memory, scale and mix pipeline.
//
// Takes one command transaction per clock when not stalled by back-pressure and
// returns one result transaction per command. Clip frames live in a single-port
// memory of CLIP_FRAMES words; a load writes it and a render reads it in the
// acceptance cycle, so each command uses the port at most once. Playback
// control (length, playhead, play and loop flags) updates at acceptance; the
// frame then passes through a multiply stage and a round/saturate stage into
// the output register. The clip memory needs no clearing after reset: only
// frames below the clip length are ever read. Configuration writes belong in
// idle periods.
`default_nettype none
module looping_pcm_sample_player_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // left_sample, right_sample, loop_request, mix_left, mix_right, zero pad
    input  wire logic [lpsp_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // command
    input  wire logic [lpsp_pkg::CMD_W-1:0]        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // out_left, out_right, playing, status, zero pad
    output logic      [lpsp_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [lpsp_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [lpsp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import lpsp_pkg::*;

    localparam int SB = SAMPLE_BITS;

    // configuration
    logic [GAIN_W-1:0] r_gain;
    logic              r_stereo;

    // playback control
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_ph, n_ph;
    logic             r_play, n_play;
    logic             r_loop, n_loop;

    // input fields
    t_cmd              in_cmd;
    logic [SB-1:0]     in_left, in_right, in_mixl, in_mixr;
    logic              in_loop;

    // handshake / stage enables
    logic en_out, en2, en1, acc;

    // stage 0 decode
    t_status          s0_status;
    logic             s0_render;
    logic             ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [FRAME_W-1:0] ram_rdata;

    // stage 1
    logic          r_v1, r_render1, r_play1;
    t_status       r_status1;
    logic [SB-1:0] r_mixl1, r_mixr1;
    logic signed [SB:0]       op_l, op_r;
    logic signed [PROD_W-1:0] prod_l, prod_r;

    // stage 2
    logic          r_v2, r_render2, r_play2;
    t_status       r_status2;
    logic [SB-1:0] r_mixl2, r_mixr2;
    logic signed [PROD_W-1:0] r_prod_l2, r_prod_r2;
    logic signed [PROD_W-1:0] rnd_l, rnd_r;
    logic [SB-1:0] sat_l, sat_r;

    // output register
    logic          r_ov, r_oplay;
    t_status       r_ostatus;
    logic [SB-1:0] r_oleft, r_oright;

    function automatic logic [SB-1:0] sat_mix(input logic [SB-1:0] mix,
                                              input logic signed [PROD_W-1:0] add);
        logic signed [PROD_W:0] sum;
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        sum = $signed({{(PROD_W+1-SB){mix[SB-1]}}, mix}) + $signed({add[PROD_W-1], add});
        hi  = $signed({{(PROD_W+2-SB){1'b0}}, {(SB-1){1'b1}}});
        lo  = $signed({{(PROD_W+2-SB){1'b1}}, {(SB-1){1'b0}}});
        if (sum > hi) begin
            sat_mix = {1'b0, {(SB-1){1'b1}}};
        end else if (sum < lo) begin
            sat_mix = {1'b1, {(SB-1){1'b0}}};
        end else begin
            sat_mix = sum[SB-1:0];
        end
    endfunction

    assign in_cmd   = t_cmd'(i_s_axis_tuser);
    assign in_left  = i_s_axis_tdata[SB-1:0];
    assign in_right = i_s_axis_tdata[2*SB-1:SB];
    assign in_loop  = i_s_axis_tdata[2*SB];
    assign in_mixl  = i_s_axis_tdata[3*SB:2*SB+1];
    assign in_mixr  = i_s_axis_tdata[4*SB:3*SB+1];

    assign en_out          = !r_ov || i_m_axis_tready;
    assign en2             = !r_v2 || en_out;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1;
    assign acc             = i_s_axis_tvalid && en1;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN: r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_MODE: r_stereo <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // command decode and control update
    always_comb begin
        n_len     = r_len;
        n_ph      = r_ph;
        n_play    = r_play;
        n_loop    = r_loop;
        s0_status = ST_OK;
        s0_render = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_ph[ADDR_W-1:0];
        case (in_cmd)
            CMD_LOAD: begin
                n_play   = 1'b0;
                n_ph     = '0;
                ram_addr = r_len[ADDR_W-1:0];
                if (r_len >= LEN_W'(CLIP_FRAMES)) begin
                    s0_status = ST_LOAD_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_len  = r_len + LEN_W'(1);
                end
            end
            CMD_PLAY: begin
                if (r_len == '0) begin
                    s0_status = ST_PLAY_EMPTY;
                end else begin
                    n_loop = in_loop;
                    n_ph   = '0;
                    n_play = 1'b1;
                end
            end
            CMD_STOP: begin
                n_play = 1'b0;
                n_ph   = '0;
            end
            CMD_CLEAR: begin
                n_play = 1'b0;
                n_len  = '0;
                n_ph   = '0;
            end
            CMD_RENDER: begin
                if (r_play && r_len != '0) begin
                    if (r_ph >= r_len) begin
                        if (r_loop) begin
                            // wrap and render frame zero
                            ram_addr  = '0;
                            n_ph      = LEN_W'(1);
                            s0_render = 1'b1;
                        end else begin
                            n_play = 1'b0;
                        end
                    end else begin
                        n_ph      = r_ph + LEN_W'(1);
                        s0_render = 1'b1;
                    end
                end else begin
                    n_play = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign ram_en = acc && (ram_we || s0_render);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ph   <= '0;
            r_play <= 1'b0;
            r_loop <= 1'b0;
        end else if (acc) begin
            r_len  <= n_len;
            r_ph   <= n_ph;
            r_play <= n_play;
            r_loop <= n_loop;
        end
    end

    lpsp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (CLIP_FRAMES)
    ) u_clip_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({in_right, in_left}),
        .o_rdata (ram_rdata)
    );

    // stage 1: frame arrives from memory, multiply by gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_render1 <= s0_render;
            r_play1   <= n_play;
            r_status1 <= s0_status;
            r_mixl1   <= in_mixl;
            r_mixr1   <= in_mixr;
        end
    end

    // mono feeds left + right into the left product and shifts one more bit
    always_comb begin
        op_r = $signed({ram_rdata[FRAME_W-1], ram_rdata[FRAME_W-1:SB]});
        if (r_stereo) begin
            op_l = $signed({ram_rdata[SB-1], ram_rdata[SB-1:0]});
        end else begin
            op_l = $signed({ram_rdata[SB-1], ram_rdata[SB-1:0]}) + op_r;
        end
    end

    assign prod_l = $signed({{(PROD_W-SB-1){op_l[SB]}}, op_l})
                    * $signed({{(PROD_W-GAIN_W){1'b0}}, r_gain});
    assign prod_r = $signed({{(PROD_W-SB-1){op_r[SB]}}, op_r})
                    * $signed({{(PROD_W-GAIN_W){1'b0}}, r_gain});

    // stage 2: round to nearest (ties up), add to mix, saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_render2 <= r_render1;
            r_play2   <= r_play1;
            r_status2 <= r_status1;
            r_mixl2   <= r_mixl1;
            r_mixr2   <= r_mixr1;
            r_prod_l2 <= prod_l;
            r_prod_r2 <= prod_r;
        end
    end

    always_comb begin
        if (r_stereo) begin
            rnd_l = (r_prod_l2 + PROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        end else begin
            rnd_l = (r_prod_l2 + PROD_W'(1 << GAIN_FRAC)) >>> (GAIN_FRAC + 1);
        end
        rnd_r = (r_prod_r2 + PROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        sat_l = sat_mix(r_mixl2, rnd_l);
        sat_r = sat_mix(r_mixr2, rnd_r);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_oplay   <= r_play2;
            r_ostatus <= r_status2;
            r_oleft   <= r_render2 ? sat_l : r_mixl2;
            r_oright  <= (r_render2 && r_stereo) ? sat_r : r_mixr2;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                              r_ostatus, r_oplay, r_oright, r_oleft};

endmodule
`default_nettype wire

>>> src/lpsp_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module lpsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
